// File: rtl/apu_pkg.sv
// Shared types and constants for the alpha premultiply unit.
package apu_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_WIDE      = 2'd1;
    localparam logic [1:0] REG_LEAD      = 2'd2;

    localparam int COMP_W  = 16;            // component width
    localparam int LANES   = 3;             // color lanes per pixel
    localparam int QUO_W   = 17;            // quotient bits, top bit flags overflow
    localparam int REM_W   = 32;            // dividend / remainder width
    localparam int DSH_W   = REM_W + 1;     // shifted divisor with compare headroom

    // 8-bit premultiply: ((t>>8)+t)>>8 with t=c*a+128 is round(c*a/255),
    // which equals floor((c*a+127)/255) for 8-bit c and a
    localparam logic [REM_W-1:0]  PREMUL_BIAS = 32'd127;
    localparam logic [COMP_W-1:0] MAX8        = 16'd255;
    localparam logic [COMP_W-1:0] MAX16       = 16'd65535;

    // One pixel word as it moves through the divider cells
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [COMP_W-1:0]           divisor;
        logic [COMP_W-1:0]           alpha;
        logic                        dir;
        logic                        wide;
        logic                        lead;
        logic                        span;
    } item_t;

endpackage

// File: rtl/apu_front.sv
// Front end: component masking, alpha selection and dividend/divisor setup.
module apu_front import apu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COMP_W-1:0]   s_chan_0,
    input  logic [COMP_W-1:0]   s_chan_1,
    input  logic [COMP_W-1:0]   s_chan_2,
    input  logic [COMP_W-1:0]   s_chan_3,
    input  logic                s_span_end,
    input  logic                cfg_dir,
    input  logic                cfg_wide,
    input  logic                cfg_lead,
    output logic                out_valid,
    input  logic                out_ready,
    output item_t               out_item
);

    logic                          v1_reg;
    logic [LANES-1:0][COMP_W-1:0]  col_reg;
    logic [COMP_W-1:0]             alpha_reg;
    logic                          dir_reg, wide_reg, lead_reg, span_reg;
    logic                          ready2;

    logic                          v2_reg;
    item_t                         item_reg;
    item_t                         item_next;

    logic [LANES-1:0][COMP_W-1:0]  col_next;
    logic [COMP_W-1:0]             alpha_next;
    logic [COMP_W-1:0]             m0, m1, m2, m3;

    // Mask to eight bits unless wide, pick alpha position
    always_comb begin
        m0 = cfg_wide ? s_chan_0 : {8'd0, s_chan_0[7:0]};
        m1 = cfg_wide ? s_chan_1 : {8'd0, s_chan_1[7:0]};
        m2 = cfg_wide ? s_chan_2 : {8'd0, s_chan_2[7:0]};
        m3 = cfg_wide ? s_chan_3 : {8'd0, s_chan_3[7:0]};
        if (cfg_lead) begin
            alpha_next  = m0;
            col_next[0] = m1;
            col_next[1] = m2;
            col_next[2] = m3;
        end else begin
            alpha_next  = m3;
            col_next[0] = m0;
            col_next[1] = m1;
            col_next[2] = m2;
        end
    end

    assign s_ready = !v1_reg || ready2;

    // Stage 1: input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            col_reg   <= col_next;
            alpha_reg <= alpha_next;
            dir_reg   <= cfg_dir;
            wide_reg  <= cfg_wide;
            lead_reg  <= cfg_lead;
            span_reg  <= s_span_end;
        end
    end

    // Stage 2: product or scaled color as dividend, divisor by mode
    always_comb begin
        item_next         = '0;
        item_next.alpha   = alpha_reg;
        item_next.dir     = dir_reg;
        item_next.wide    = wide_reg;
        item_next.lead    = lead_reg;
        item_next.span    = span_reg;
        item_next.divisor = dir_reg ? alpha_reg : (wide_reg ? MAX16 : MAX8);
        for (int i = 0; i < LANES; i++) begin
            if (!dir_reg) begin
                item_next.rem[i] = (REM_W'(col_reg[i]) * REM_W'(alpha_reg))
                                   + (wide_reg ? '0 : PREMUL_BIAS);
            end else if (wide_reg) begin
                item_next.rem[i] = {col_reg[i], 16'd0} - {16'd0, col_reg[i]};
            end else begin
                item_next.rem[i] = {8'd0, col_reg[i], 8'd0} - {16'd0, col_reg[i]};
            end
        end
    end

    assign ready2 = !v2_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/apu_cell.sv
// Divider cell: resolves one quotient bit for all three color lanes.
module apu_cell import apu_pkg::*; #(
    parameter int BIT = 16
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output item_t  out_item
);

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [DSH_W-1:0] dsh;

    // Restoring step: subtract divisor << BIT where it fits
    always_comb begin
        item_next = in_item;
        dsh       = {{(DSH_W-COMP_W){1'b0}}, in_item.divisor} << BIT;
        for (int i = 0; i < LANES; i++) begin
            if ({1'b0, in_item.rem[i]} >= dsh) begin
                item_next.rem[i]      = in_item.rem[i] - dsh[REM_W-1:0];
                item_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/alpha_premultiply_unit_top.sv
// Top level of the alpha premultiply unit: config, divider chain, output stage.
//
// Takes one RGBA pixel word per clock on the s_ channel and returns the
// converted word on the m_ channel, same channel order. Three one-bit
// registers on the cfg port pick the direction (premultiply or
// unpremultiply), 8- or 16-bit components, and the alpha position; write
// them only while the unit is empty.
// Every conversion is a quotient: premultiply divides c*a (+127 in 8-bit
// mode) by 255 or 65535, unpremultiply divides c*255 or c*65535 by alpha.
// The quotient comes out of a row of 17 divider cells, one bit per cell,
// all three color lanes side by side.
// The registers in order: input register, dividend setup, 17 cells and the
// output register. Throughput is one word per clock while m_ready is high.
// Reset (aresetn, synchronous, active low) empties the pipeline and clears
// the config registers to zero. When m_ready is low the words stop in
// place; s_ready drops only once every stage holds a word.
module alpha_premultiply_unit_top import apu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [0:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COMP_W-1:0]   s_chan_0,
    input  logic [COMP_W-1:0]   s_chan_1,
    input  logic [COMP_W-1:0]   s_chan_2,
    input  logic [COMP_W-1:0]   s_chan_3,
    input  logic                s_span_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COMP_W-1:0]   m_res_0,
    output logic [COMP_W-1:0]   m_res_1,
    output logic [COMP_W-1:0]   m_res_2,
    output logic [COMP_W-1:0]   m_res_3,
    output logic                m_span_done
);

    localparam int NCELL = QUO_W;

    logic dir_reg, wide_reg, lead_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= 1'b0;
            wide_reg <= 1'b0;
            lead_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DIRECTION: dir_reg  <= cfg_data[0];
                REG_WIDE:      wide_reg <= cfg_data[0];
                REG_LEAD:      lead_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic  [NCELL:0] vld;
    logic  [NCELL:0] rdy;
    item_t           itm [NCELL+1];

    apu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_chan_0   (s_chan_0),
        .s_chan_1   (s_chan_1),
        .s_chan_2   (s_chan_2),
        .s_chan_3   (s_chan_3),
        .s_span_end (s_span_end),
        .cfg_dir    (dir_reg),
        .cfg_wide   (wide_reg),
        .cfg_lead   (lead_reg),
        .out_valid  (vld[0]),
        .out_ready  (rdy[0]),
        .out_item   (itm[0])
    );

    // Divider row, most significant quotient bit first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        apu_cell #(.BIT(NCELL - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_item   (itm[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_item  (itm[g+1])
        );
    end

    // Output stage: saturation, zero alpha, channel placement
    logic                          out_valid_reg;
    logic [3:0][COMP_W-1:0]        res_reg, res_next;
    logic                          span_reg;
    logic                          owide_reg, odir_reg, olead_reg;
    logic [LANES-1:0][COMP_W-1:0]  lane;
    item_t                         fin;

    assign fin = itm[NCELL];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (fin.dir && fin.alpha == '0) begin
                lane[i] = '0;
            end else if (fin.quo[i][QUO_W-1]
                         || (!fin.wide && fin.quo[i][15:8] != 8'd0)) begin
                lane[i] = fin.wide ? MAX16 : MAX8;
            end else begin
                lane[i] = fin.quo[i][COMP_W-1:0];
            end
        end
        if (fin.lead) begin
            res_next = {lane[2], lane[1], lane[0], fin.alpha};
        end else begin
            res_next = {fin.alpha, lane[2], lane[1], lane[0]};
        end
    end

    assign rdy[NCELL] = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rdy[NCELL]) begin
            out_valid_reg <= vld[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NCELL] && vld[NCELL]) begin
            res_reg   <= res_next;
            span_reg  <= fin.span;
            owide_reg <= fin.wide;
            odir_reg  <= fin.dir;
            olead_reg <= fin.lead;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_res_0     = res_reg[0];
    assign m_res_1     = res_reg[1];
    assign m_res_2     = res_reg[2];
    assign m_res_3     = res_reg[3];
    assign m_span_done = span_reg;

    // Input side only stalls when the output is blocked
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    // 8-bit words leave with clear upper bytes
    a_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !owide_reg) |-> (m_res_0[15:8] == 8'd0 && m_res_1[15:8] == 8'd0
            && m_res_2[15:8] == 8'd0 && m_res_3[15:8] == 8'd0))
        else $error("upper byte set in 8-bit mode");

    // Unpremultiply with zero alpha gives zero colors (alpha last)
    a_zero_alpha_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && odir_reg && m_res_3 == '0 && !olead_reg)
            |-> (m_res_0 == '0 && m_res_1 == '0 && m_res_2 == '0))
        else $error("nonzero color with zero alpha");

    // Same with alpha first
    a_zero_alpha_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && odir_reg && m_res_0 == '0 && olead_reg)
            |-> (m_res_1 == '0 && m_res_2 == '0 && m_res_3 == '0))
        else $error("nonzero color with zero alpha");

endmodule

// File: tb/apu_checker.sv
// Checker for the alpha premultiply unit: predicts each pixel word and compares results.
module apu_checker import apu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [0:0]        cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [COMP_W-1:0] s_chan_0,
    input  logic [COMP_W-1:0] s_chan_1,
    input  logic [COMP_W-1:0] s_chan_2,
    input  logic [COMP_W-1:0] s_chan_3,
    input  logic              s_span_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [COMP_W-1:0] m_res_0,
    input  logic [COMP_W-1:0] m_res_1,
    input  logic [COMP_W-1:0] m_res_2,
    input  logic [COMP_W-1:0] m_res_3,
    input  logic              m_span_done,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0][COMP_W-1:0] comp;
        logic                   span;
    } pixel_t;

    pixel_t pixel_q[$];
    logic   cfg_dir, cfg_wide, cfg_lead;

    // One converted component
    function automatic logic [COMP_W-1:0] scale_comp(logic [31:0] c, logic [31:0] a,
                                                     logic dir, logic wide);
        logic [31:0] t, q;
        if (!dir) begin
            if (wide) return 16'((c * a) / 32'd65535);
            t = c * a + 32'd128;
            return 16'(((t >> 8) + t) >> 8);
        end
        if (a == 0) return '0;
        if (wide) begin
            q = (c * 32'd65535) / a;
            return (q > 32'd65535) ? 16'hFFFF : q[15:0];
        end
        q = (c * 32'd255) / a;
        return (q > 32'd255) ? 16'd255 : q[15:0];
    endfunction

    function automatic pixel_t convert_pixel(pixel_t px);
        pixel_t      r;
        logic [31:0] a;
        int          apos;
        apos = cfg_lead ? 0 : 3;
        for (int i = 0; i < 4; i++)
            px.comp[i] = cfg_wide ? px.comp[i] : {8'd0, px.comp[i][7:0]};
        a = 32'(px.comp[apos]);
        r = px;
        for (int i = 0; i < 4; i++)
            if (i != apos)
                r.comp[i] = scale_comp(32'(px.comp[i]), a, cfg_dir, cfg_wide);
        if (cfg_dir && a == 0 && !cfg_wide) r.comp[apos] = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    assign pending = pixel_q.size();

    // Track config, queue predictions, compare results
    always @(posedge aclk) begin
        pixel_t px, w;
        if (!aresetn) begin
            cfg_dir <= 0; cfg_wide <= 0; cfg_lead <= 0;
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIRECTION: cfg_dir  <= cfg_data[0];
                    REG_WIDE:      cfg_wide <= cfg_data[0];
                    REG_LEAD:      cfg_lead <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                px.comp = {s_chan_3, s_chan_2, s_chan_1, s_chan_0};
                px.span = s_span_end;
                pixel_q.push_back(convert_pixel(px));
            end
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected word", m_res_0, 0);
                end else begin
                    w = pixel_q.pop_front();
                    if (m_res_0 !== w.comp[0]) report_mismatch("res_0", m_res_0, w.comp[0]);
                    if (m_res_1 !== w.comp[1]) report_mismatch("res_1", m_res_1, w.comp[1]);
                    if (m_res_2 !== w.comp[2]) report_mismatch("res_2", m_res_2, w.comp[2]);
                    if (m_res_3 !== w.comp[3]) report_mismatch("res_3", m_res_3, w.comp[3]);
                    if (m_span_done !== w.span)
                        report_mismatch("span_done", m_span_done, w.span);
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
// Stimulus, clock, reset and verdict for the alpha premultiply unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import apu_pkg::*;

    localparam int WATCHDOG = 20000;

    logic              aclk = 0, aresetn = 0;
    logic              cfg_we = 0;
    logic [1:0]        cfg_index = REG_DIRECTION;
    logic [0:0]        cfg_data = 0;
    logic              s_valid = 0, s_ready;
    logic [COMP_W-1:0] s_chan_0 = 0, s_chan_1 = 0, s_chan_2 = 0, s_chan_3 = 0;
    logic              s_span_end = 0;
    logic              m_valid, m_ready = 0;
    logic [COMP_W-1:0] m_res_0, m_res_1, m_res_2, m_res_3;
    logic              m_span_done;
    int                fail_count, pending;
    int                idle_cycles = 0;
    bit                calm = 0, hold_off = 0;

    always #6 aclk = ~aclk;

    alpha_premultiply_unit_top dut (.*);
    apu_checker chk (.*);

    // Receiver: random stalls, one long hold-off, calm stretch
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 0;
        else m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[alpha_premultiply_unit_top] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic val);
        @(negedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic set_mode(logic dir, logic wide, logic lead);
        write_reg(REG_DIRECTION, dir);
        write_reg(REG_WIDE, wide);
        write_reg(REG_LEAD, lead);
    endtask

    // Drive one word; called at a falling edge, valid stays up for the next word
    task automatic send_pixel(logic [15:0] c0, c1, c2, c3, logic span);
        while (!calm && $urandom_range(99) < 21) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_chan_0 <= c0; s_chan_1 <= c1; s_chan_2 <= c2; s_chan_3 <= c3;
        s_span_end <= span;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp(logic wide);
        case ($urandom_range(5))
            0: return 16'd0;
            1: return wide ? 16'hFFFF : 16'h00FF;
            2: return 16'($urandom_range(3));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] a;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // Directed: extremes in every mode, zero alpha, color above alpha
        for (int m = 0; m < 8; m++) begin
            set_mode(m[0], m[1], m[2]);
            send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
            send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
            send_pixel(16'h1234, 16'hFF80, 16'h00FF, 16'h0000, 1);
            drain();
        end
        // Random phases, each with a randomly chosen mode
        for (int ph = 0; ph < 17; ph++) begin
            set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            calm = (ph == 5);
            if (ph == 9) fork
                begin
                    hold_off = 1;
                    repeat (200) @(negedge aclk);
                    hold_off = 0;
                end
            join_none
            for (int i = 0; i < 50; i++) begin
                a = rand_comp(1'($urandom_range(1)));
                if ($urandom_range(3) == 0)
                    send_pixel(a, rand_comp(1), rand_comp(1), a, 1'($urandom_range(1)));
                else
                    send_pixel(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1),
                               1'($urandom_range(1)));
            end
            calm = 0;
            drain();
        end
        if (fail_count == 0) $display("[alpha_premultiply_unit_top] OK");
        else $display("[alpha_premultiply_unit_top] ERROR");
        $finish;
    end
endmodule
